### rtl/qpf_pkg.sv
// Shared types, constants and tap table of the quarter-pel four-tap luma filter.
package qpf_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int SAMPLE_W       = 8;
	localparam int WIN_W          = 3 * SAMPLE_W;
	localparam int ROW_CNT_W      = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;
	localparam int SUM_W          = 16;
	localparam int TAP_W          = 7;
	localparam int ROUND_OFS      = 16;
	localparam int OUT_SHIFT      = 5;
	localparam int OUT_FIFO_DEPTH = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_POS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;

	localparam logic       RST_DIRECTION    = 1'b0;
	localparam logic [1:0] RST_FRAC_POS     = 2'd2;
	localparam logic [6:0] RST_BLOCK_WIDTH  = 7'd8;
	localparam logic [6:0] RST_BLOCK_HEIGHT = 7'd8;

	// One request as it leaves the counter logic.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                emit;
		logic                last;
		logic                vert;
		logic [WIN_W-1:0]    row_win;
	} item_t;

	// Four filter operands and flags, oldest sample in a.
	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] c;
		logic [SAMPLE_W-1:0] d;
		logic                emit;
		logic                last;
	} tap_in_t;

	// Tap k of the set chosen by the fractional position; position zero is a plain copy.
	function automatic logic signed [TAP_W-1:0] tap_coef(input logic [1:0] frac,
		input logic [1:0] k);
		logic signed [TAP_W-1:0] t;
		t = '0;
		case ({frac, k})
			4'b00_01: t = 7'sd32;
			4'b01_00: t = -7'sd1;
			4'b01_01: t = 7'sd25;
			4'b01_10: t = 7'sd9;
			4'b01_11: t = -7'sd1;
			4'b10_00: t = -7'sd2;
			4'b10_01: t = 7'sd18;
			4'b10_10: t = 7'sd18;
			4'b10_11: t = -7'sd2;
			4'b11_00: t = -7'sd1;
			4'b11_01: t = 7'sd9;
			4'b11_10: t = 7'sd25;
			4'b11_11: t = -7'sd1;
			default:  t = '0;
		endcase
		return t;
	endfunction

endpackage

### rtl/qpf_ctrl.sv
// Configuration registers, row and column counters and the horizontal sample window.
module qpf_ctrl import qpf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [SAMPLE_W-1:0]           ref_sample,
	output logic                          acc,
	output item_t                         item,
	output logic [$clog2(MAX_WIDTH)-1:0]  col,
	output logic [1:0]                    frac_pos
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 4);

	logic                 dir_q;
	logic [1:0]           frac_q;
	logic [6:0]           bw_q;
	logic [6:0]           bh_q;
	logic [CW-1:0]        col_cnt_q;
	logic [ROW_CNT_W-1:0] row_cnt_q;
	logic [WIN_W-1:0]     row_win_q;

	logic [CW-1:0]        w_eff;
	logic [ROW_CNT_W-1:0] h_eff;
	logic [CW-1:0]        col_nxt;
	logic [ROW_CNT_W-1:0] row_nxt;
	logic                 emit;
	logic                 row_end;
	logic                 blk_end;
	logic                 cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index <= REG_BLOCK_HEIGHT);
	assign acc       = in_valid && !in_stall;
	assign frac_pos  = frac_q;

	always_comb begin
		if (bw_q == '0) begin
			w_eff = CW'(1);
		end else if (ROW_CNT_W'(bw_q) > ROW_CNT_W'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(bw_q);
		end
		h_eff = (bh_q == '0) ? ROW_CNT_W'(1) : ROW_CNT_W'(bh_q);
	end

	assign col_nxt = col_cnt_q + CW'(1);
	assign row_nxt = row_cnt_q + ROW_CNT_W'(1);

	always_comb begin
		if (dir_q) begin
			emit    = row_cnt_q >= ROW_CNT_W'(3);
			row_end = col_nxt >= w_eff;
			blk_end = row_end && (row_nxt >= h_eff + ROW_CNT_W'(3));
		end else begin
			emit    = col_cnt_q >= CW'(3);
			row_end = col_nxt >= w_eff + CW'(3);
			blk_end = row_end && (row_nxt >= h_eff);
		end
	end

	assign item.sample  = ref_sample;
	assign item.emit    = emit;
	assign item.last    = emit && blk_end;
	assign item.vert    = dir_q;
	assign item.row_win = row_win_q;
	// In vertical mode the count stays below the width, so its low bits are the column.
	assign col          = col_cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= RST_DIRECTION;
			frac_q    <= RST_FRAC_POS;
			bw_q      <= RST_BLOCK_WIDTH;
			bh_q      <= RST_BLOCK_HEIGHT;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			row_win_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_DIRECTION:    dir_q  <= cfg_data[0];
				REG_FRAC_POS:     frac_q <= cfg_data[1:0];
				REG_BLOCK_WIDTH:  bw_q   <= cfg_data[6:0];
				REG_BLOCK_HEIGHT: bh_q   <= cfg_data[6:0];
				default:          dir_q  <= dir_q;
			endcase
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			row_win_q <= '0;
		end else if (acc) begin
			if (!dir_q) begin
				row_win_q <= row_end ? '0 : {row_win_q[2*SAMPLE_W-1:0], ref_sample};
			end
			if (row_end) begin
				col_cnt_q <= '0;
				row_cnt_q <= blk_end ? '0 : row_nxt;
			end else begin
				col_cnt_q <= col_nxt;
			end
		end
	end

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_cnt_q < w_eff + CW'(3))
		else $error("column count ran past the row");

	a_vert_col: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q |-> col_cnt_q < w_eff)
		else $error("vertical column count ran past the width");

endmodule

### rtl/qpf_line_mem.sv
// Line memory of the three previous rows per column, read-modify-write with forwarding.
module qpf_line_mem import qpf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  item_t                         item,
	input  logic [$clog2(MAX_WIDTH)-1:0]  col,
	output logic                          busy_s1,
	output tap_in_t                       tin_s2
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [WIN_W-1:0] mem [MAX_WIDTH];
	logic [WIN_W-1:0] rd_q;
	logic [WIN_W-1:0] wr_q;
	logic             v_s1;
	logic             fwd_s1;
	item_t            item_s1;
	logic [AW-1:0]    col_s1;
	logic [WIN_W-1:0] win_s1;
	logic [WIN_W-1:0] new_word;

	// A request right behind one on the same column would read the stale word.
	assign win_s1   = item_s1.vert ? (fwd_s1 ? wr_q : rd_q) : item_s1.row_win;
	assign new_word = {win_s1[2*SAMPLE_W-1:0], item_s1.sample};
	assign busy_s1  = v_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= mem[col];
		end
		if (v_s1 && item_s1.vert) begin
			mem[col_s1] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item;
			col_s1  <= col;
		end
		if (v_s1) begin
			wr_q <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			tin_s2 <= '0;
		end else begin
			v_s1         <= acc;
			fwd_s1       <= acc && v_s1 && item_s1.vert && item.vert && (col == col_s1);
			tin_s2.valid <= v_s1;
			tin_s2.a     <= win_s1[3*SAMPLE_W-1:2*SAMPLE_W];
			tin_s2.b     <= win_s1[2*SAMPLE_W-1:SAMPLE_W];
			tin_s2.c     <= win_s1[SAMPLE_W-1:0];
			tin_s2.d     <= item_s1.sample;
			tin_s2.emit  <= item_s1.emit;
			tin_s2.last  <= item_s1.last;
		end
	end

	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1 && $past(v_s1) && (col_s1 == $past(col_s1)))
		else $error("forwarding taken without a write to the same column");

endmodule

### rtl/qpf_filter.sv
// Four-tap weighted sum, rounding shift and clamp to eight bits.
module qpf_filter import qpf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  tap_in_t             tin_s2,
	input  logic [1:0]          frac_pos,
	output logic                busy_s3,
	output logic                push,
	output logic [SAMPLE_W-1:0] px,
	output logic                px_last
);

	logic signed [SUM_W-1:0] p0;
	logic signed [SUM_W-1:0] p1;
	logic signed [SUM_W-1:0] p2;
	logic signed [SUM_W-1:0] p3;
	logic signed [SUM_W-1:0] sum_s3;
	logic signed [SUM_W-1:0] shifted;
	logic                    v_s3;
	logic                    emit_s3;
	logic                    last_s3;

	assign p0 = SUM_W'(tap_coef(frac_pos, 2'd0)) * $signed(SUM_W'(tin_s2.a));
	assign p1 = SUM_W'(tap_coef(frac_pos, 2'd1)) * $signed(SUM_W'(tin_s2.b));
	assign p2 = SUM_W'(tap_coef(frac_pos, 2'd2)) * $signed(SUM_W'(tin_s2.c));
	assign p3 = SUM_W'(tap_coef(frac_pos, 2'd3)) * $signed(SUM_W'(tin_s2.d));

	always_ff @(posedge clk) begin
		sum_s3  <= p0 + p1 + p2 + p3 + SUM_W'(ROUND_OFS);
		emit_s3 <= tin_s2.emit;
		last_s3 <= tin_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= tin_s2.valid;
		end
	end

	assign shifted = sum_s3 >>> OUT_SHIFT;

	always_comb begin
		if (sum_s3[SUM_W-1]) begin
			px = '0;
		end else if (shifted[SUM_W-1:SAMPLE_W] != '0) begin
			px = '1;
		end else begin
			px = shifted[SAMPLE_W-1:0];
		end
	end

	assign push    = v_s3 && emit_s3;
	assign px_last = last_s3;
	assign busy_s3 = v_s3;

endmodule

### rtl/qpf_out_fifo.sv
// Output queue that keeps the filter pipeline running while the consumer stalls.
module qpf_out_fifo import qpf_pkg::*; #(
	parameter int DEPTH = OUT_FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [SAMPLE_W-1:0]        px,
	input  logic                       px_last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [SAMPLE_W-1:0]        out_pixel,
	output logic                       last_of_block,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [SAMPLE_W:0] buf_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     cnt_q;
	logic              pop;

	assign out_valid     = cnt_q != '0;
	assign pop           = out_valid && !out_stall;
	assign out_pixel     = buf_q[rd_ptr_q][SAMPLE_W:1];
	assign last_of_block = buf_q[rd_ptr_q][0];
	assign count         = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= {px, px_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != NW'(DEPTH))
		else $error("result pushed into a full output queue");

endmodule

### rtl/quarter_pel_four_tap_luma_filter.sv
// Top level of the quarter-pel four-tap luma filter, horizontal or vertical.
// Path: a sample passes stage s1, the tin_s2 and s3 registers and the output queue.
// Throughput: one sample per cycle in both modes while in_stall is low; the line memory
// reads and writes at once and forwards a same-column write to the next request.
// Reset clears counters and the row window and loads register defaults; the line memory
// is not cleared, since every column is rewritten three times before it is read.
module quarter_pel_four_tap_luma_filter import qpf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SAMPLE_W-1:0]   ref_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SAMPLE_W-1:0]   out_pixel,
	output logic                  last_of_block
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int NW = $clog2(OUT_FIFO_DEPTH + 1);

	logic                acc;
	item_t               item;
	logic [AW-1:0]       col;
	logic [1:0]          frac_pos;
	logic                busy_s1;
	tap_in_t             tin_s2;
	logic                busy_s3;
	logic                push;
	logic [SAMPLE_W-1:0] px;
	logic                px_last;
	logic [NW-1:0]       fifo_cnt;
	logic [NW:0]         in_flight;

	// Every request in the pipeline holds a queue slot until it leaves.
	assign in_flight = (NW+1)'(fifo_cnt) + (NW+1)'(busy_s1) + (NW+1)'(tin_s2.valid)
		+ (NW+1)'(busy_s3);
	assign in_stall  = in_flight >= (NW+1)'(OUT_FIFO_DEPTH);

	qpf_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ref_sample (ref_sample),
		.acc        (acc),
		.item       (item),
		.col        (col),
		.frac_pos   (frac_pos)
	);

	qpf_line_mem #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.item    (item),
		.col     (col),
		.busy_s1 (busy_s1),
		.tin_s2  (tin_s2)
	);

	qpf_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.tin_s2   (tin_s2),
		.frac_pos (frac_pos),
		.busy_s3  (busy_s3),
		.push     (push),
		.px       (px),
		.px_last  (px_last)
	);

	qpf_out_fifo #(
		.DEPTH(OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.px            (px),
		.px_last       (px_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_pixel     (out_pixel),
		.last_of_block (last_of_block),
		.count         (fifo_cnt)
	);

endmodule

### test/testbench.sv
// Self-checking testbench for the quarter-pel four-tap luma filter.
`timescale 1ns / 100ps

module testbench;
	import qpf_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] pixel;
		logic                last;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   ref_sample;
	logic                  out_valid;
	logic                  out_stall;
	logic [SAMPLE_W-1:0]   out_pixel;
	logic                  last_of_block;

	// Predictor copy of the registers and the filter state.
	logic                  reg_direction = RST_DIRECTION;
	logic [1:0]            reg_frac = RST_FRAC_POS;
	logic [6:0]            reg_width = RST_BLOCK_WIDTH;
	logic [6:0]            reg_height = RST_BLOCK_HEIGHT;
	logic [WIN_W-1:0]      row_window = '0;
	logic [WIN_W-1:0]      line_store [MAX_WIDTH_DEF];
	int                    column_count = 0;
	int                    row_count = 0;

	pixel_t                expected_pixels [$];
	int                    error_count = 0;
	logic                  no_idle = 1'b0;
	int                    random_sent = 0;

	quarter_pel_four_tap_luma_filter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.ref_sample    (ref_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_pixel     (out_pixel),
		.last_of_block (last_of_block)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [SAMPLE_W-1:0] interpolate(input logic [WIN_W-1:0] win,
		input logic [SAMPLE_W-1:0] cur);
		int a, b, c, d, acc;
		a = int'(win[23:16]);
		b = int'(win[15:8]);
		c = int'(win[7:0]);
		d = int'(cur);
		case (reg_frac)
			2'd0:    acc = 32 * b;
			2'd1:    acc = -a + 25 * b + 9 * c - d;
			2'd2:    acc = -2 * a + 18 * b + 18 * c - 2 * d;
			default: acc = -a + 9 * b + 25 * c - d;
		endcase
		acc = acc + 16;
		if (acc < 0)
			return '0;
		acc = acc >>> 5;
		if (acc > 255)
			return 8'd255;
		return acc[7:0];
	endfunction

	function automatic int active_width();
		if (reg_width == 0)
			return 1;
		if (int'(reg_width) > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return int'(reg_width);
	endfunction

	function automatic int active_height();
		return (reg_height == 0) ? 1 : int'(reg_height);
	endfunction

	function automatic int samples_per_block();
		if (reg_direction)
			return active_width() * (active_height() + 3);
		return (active_width() + 3) * active_height();
	endfunction

	// Advances the predictor by one sample and queues the pixel it yields, if any.
	task automatic filter_step(input logic [SAMPLE_W-1:0] s);
		int     w, h, col;
		pixel_t p;
		logic   produce;
		logic   block_done;
		w = active_width();
		h = active_height();
		produce = 1'b0;
		block_done = 1'b0;
		p = '0;
		if (!reg_direction) begin
			if (column_count >= 3) begin
				p.pixel = interpolate(row_window, s);
				produce = 1'b1;
			end
			row_window = {row_window[15:0], s};
			column_count++;
			if (column_count >= w + 3) begin
				column_count = 0;
				row_window = '0;
				row_count++;
				if (row_count >= h) begin
					row_count = 0;
					block_done = 1'b1;
				end
			end
		end else begin
			col = (column_count < w) ? column_count : w - 1;
			if (row_count >= 3) begin
				p.pixel = interpolate(line_store[col], s);
				produce = 1'b1;
			end
			line_store[col] = {line_store[col][15:0], s};
			column_count++;
			if (column_count >= w) begin
				column_count = 0;
				row_count++;
				if (row_count >= h + 3) begin
					row_count = 0;
					block_done = 1'b1;
				end
			end
		end
		if (produce) begin
			p.last = block_done;
			expected_pixels.push_back(p);
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		logic known;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		known = 1'b1;
		case (idx)
			REG_DIRECTION:    reg_direction = data[0];
			REG_FRAC_POS:     reg_frac = data[1:0];
			REG_BLOCK_WIDTH:  reg_width = data;
			REG_BLOCK_HEIGHT: reg_height = data;
			default:          known = 1'b0;
		endcase
		// Any write to a real register restarts the block; the line memory is kept.
		if (known) begin
			row_window = '0;
			column_count = 0;
			row_count = 0;
		end
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		while (!no_idle && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ref_sample <= s;
		filter_step(s);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Lets every expected pixel come out, then a few more cycles for requests still in flight.
	task automatic wait_idle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (expected_pixels.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", expected_pixels.size());
			error_count++;
			expected_pixels.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return SAMPLE_W'($urandom_range(255));
		endcase
	endfunction

	// Reset defaults, and writes to unused indexes that must not restart the row.
	task automatic test_defaults();
		logic [SAMPLE_W-1:0] first_half [5] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
		logic [SAMPLE_W-1:0] second_half [6] = '{8'd0, 8'd255, 8'd0, 8'd128, 8'd64, 8'd255};
		foreach (first_half[i])
			send_sample(first_half[i]);
		wait_idle();
		for (int i = REG_BLOCK_HEIGHT + 1; i < 2 ** CFG_IDX_W; i++)
			write_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(127)));
		foreach (second_half[i])
			send_sample(second_half[i]);
		wait_idle();
	endtask

	// Every tap set on one-sample blocks, with zero width and height, hitting both clamps.
	task automatic test_tap_sets();
		logic [SAMPLE_W-1:0] pattern [4][4] = '{
			'{8'd0,   8'd255, 8'd0,   8'd0},
			'{8'd255, 8'd0,   8'd0,   8'd255},
			'{8'd0,   8'd255, 8'd255, 8'd0},
			'{8'd128, 8'd64,  8'd200, 8'd32}
		};
		write_register(REG_DIRECTION, 7'd0);
		write_register(REG_BLOCK_WIDTH, 7'd0);
		write_register(REG_BLOCK_HEIGHT, 7'd0);
		for (int f = 0; f < 4; f++) begin
			write_register(REG_FRAC_POS, CFG_DATA_W'(f));
			for (int k = 0; k < 4; k++)
				send_sample(pattern[f][k]);
			wait_idle();
		end
	endtask

	task automatic test_vertical_column();
		write_register(REG_DIRECTION, 7'd1);
		write_register(REG_BLOCK_WIDTH, 7'd1);
		write_register(REG_BLOCK_HEIGHT, 7'd0);
		send_sample(8'd255);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd255);
		wait_idle();
	endtask

	// Random settings per phase, mostly whole blocks, some cut short or running over.
	task automatic test_random_blocks();
		logic [6:0] width_raw, height_raw;
		int         count, len;
		while (random_sent < 400) begin
			case ($urandom_range(19))
				0: begin
					width_raw = 7'($urandom_range(65, 127));
					height_raw = 7'($urandom_range(2));
				end
				1: begin
					width_raw = 7'($urandom_range(2));
					height_raw = 7'($urandom_range(64, 127));
				end
				2: begin
					width_raw = 7'd64;
					height_raw = 7'($urandom_range(1, 3));
				end
				default: begin
					width_raw = ($urandom_range(3) == 0) ? 7'($urandom_range(16))
						: 7'(8 * $urandom_range(1, 2));
					height_raw = 7'($urandom_range(6));
				end
			endcase
			write_register(REG_DIRECTION, {6'($urandom_range(63)), 1'($urandom_range(1))});
			write_register(REG_FRAC_POS, CFG_DATA_W'($urandom_range(127)));
			write_register(REG_BLOCK_WIDTH, width_raw);
			write_register(REG_BLOCK_HEIGHT, height_raw);
			if ($urandom_range(7) == 0)
				write_register(CFG_IDX_W'($urandom_range(REG_BLOCK_HEIGHT + 1,
					2 ** CFG_IDX_W - 1)), CFG_DATA_W'($urandom_range(127)));
			len = samples_per_block();
			case ($urandom_range(9))
				7, 8:    count = $urandom_range(1, len);
				9:       count = $urandom_range(len, len + 20);
				default: count = (len > 200) ? len : len * $urandom_range(1, 2);
			endcase
			for (int i = 0; i < count; i++) begin
				no_idle = (random_sent >= 100 && random_sent < 220);
				send_sample(random_sample());
				random_sent++;
			end
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk)
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 27);

	always @(posedge clk) begin : check_output
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("out_pixel %0d last_of_block %0b with nothing expected",
					out_pixel, last_of_block);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_pixel !== want.pixel) begin
					$error("out_pixel expected %0d actual %0d", want.pixel, out_pixel);
					error_count++;
				end
				if (last_of_block !== want.last) begin
					$error("last_of_block expected %0b actual %0b", want.last,
						last_of_block);
					error_count++;
				end
			end
		end
	end

	initial begin
		foreach (line_store[i])
			line_store[i] = '0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		ref_sample <= '0;
		out_stall <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_tap_sets();
		test_vertical_column();
		test_random_blocks();
		wait_idle();
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
